FILE: rtl/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

  // Region geometry.
  localparam int unsigned REGION_BYTES    = 65536;
  localparam int unsigned MIN_BLOCK_BYTES = 64;
  localparam int unsigned HEADER_BYTES    = 24;
  localparam int unsigned BASE_ADDRESS    = 327680;

  localparam int unsigned LOG_REGION = $clog2(REGION_BYTES);
  localparam int unsigned LOG_MIN    = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned LEAF_LVL   = LOG_REGION - LOG_MIN;
  localparam int unsigned NODE_COUNT = 2 * (REGION_BYTES / MIN_BLOCK_BYTES) - 1;

  // Widths.
  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  localparam int unsigned LVL_W  = $clog2(LEAF_LVL + 1);
  localparam int unsigned OFF_W  = LOG_REGION;
  localparam int unsigned FB_W   = 17;
  localparam int unsigned NEED_W = LOG_REGION + 1;
  localparam int unsigned CLOG_W = $clog2(NEED_W + 1);
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned OWN_W  = 7;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned RES_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    F_ALLOC, F_FREE, F_FREE_OWNER, F_QUERY
  } func_t;

  typedef enum logic [RES_W-1:0] {
    R_OK, R_NO_SPACE, R_TOO_LARGE, R_ILLEGAL, R_NOT_ALLOC
  } res_t;

  typedef enum logic [1:0] {
    N_UNUSED, N_FREE, N_SPLIT, N_ALLOC
  } node_st_t;

  typedef struct packed {
    logic [OWN_W-1:0] owner;
    node_st_t         st;
  } node_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LATCH, OP_A_INIT, OP_RD_N, OP_RD_SC, OP_RD_SIB,
    OP_A_DOWN, OP_A_UP, OP_A_NEXT, OP_A_FOUND, OP_W_ALLOC, OP_W_SPLIT,
    OP_W_RFREE, OP_F_INIT, OP_F_DOWN, OP_W_FREE, OP_O_FREE, OP_M_WN,
    OP_M_WS, OP_M_WP, OP_SC_INC, OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_we;
    res_t   res;
  } cmd_t;

  typedef struct packed {
    func_t    func;
    node_st_t nst;
    logic     own_hit;
    logic     n_root;
    logic     n_odd;
    logic     lv_at_t;
    logic     lv_below_t;
    logic     too_big;
    logic     no_space;
    logic     adr_null;
    logic     adr_range;
    logic     adr_low;
    logic     off_hit;
    logic     sc_last;
    logic     out_busy;
  } stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_RD, S_A_VIS, S_A_UP, S_A_SPL, S_A_SPR,
    S_F_RD, S_F_VIS, S_M_RD, S_M_CHK, S_M_WS, S_M_WP, S_O_RD, S_O_CHK,
    S_O_NEXT, S_OUT
  } state_t;

  // Free bytes that one free block at a tree level contributes.
  function automatic logic [FB_W-1:0] net_bytes(input logic [LVL_W-1:0] lv);
    logic [FB_W:0] sz;
    sz = (FB_W+1)'(REGION_BYTES) >> lv;
    return FB_W'(sz - (FB_W+1)'(HEADER_BYTES));
  endfunction

  // Tree level of a node index: bit length of index plus one, minus one.
  function automatic logic [LVL_W-1:0] lvl_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] p1;
    logic [LVL_W-1:0] l;
    p1 = idx + IDX_W'(1);
    l  = '0;
    for (int b = 1; b < IDX_W; b++) begin
      if (p1[b]) l = LVL_W'(b);
    end
    return l;
  endfunction

  // Number of significant bits of a value.
  function automatic logic [CLOG_W-1:0] bit_len(input logic [NEED_W-1:0] v);
    logic [CLOG_W-1:0] n;
    n = '0;
    for (int b = 0; b < NEED_W; b++) begin
      if (v[b]) n = CLOG_W'(b + 1);
    end
    return n;
  endfunction

endpackage

FILE: rtl/bba_ctrl.sv
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bba_pkg::stat_t stat,
  output bba_pkg::cmd_t  cmd
);

  bba_pkg::state_t state_r, state_nxt, merge_done;

  // State register; reset starts the memory clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Where a finished merge walk returns to.
  assign merge_done = (stat.func == bba_pkg::F_FREE_OWNER) ? bba_pkg::S_O_NEXT
                                                            : bba_pkg::S_OUT;

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.op     = bba_pkg::OP_NONE;
    cmd.res_we = 1'b0;
    cmd.res    = bba_pkg::R_OK;
    unique case (state_r)
      bba_pkg::S_CLEAR: begin
        cmd.op = bba_pkg::OP_CLR;
        if (stat.sc_last) state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bba_pkg::OP_LATCH;
          state_nxt = bba_pkg::S_DISPATCH;
        end
      end
      bba_pkg::S_DISPATCH: begin
        unique case (stat.func)
          bba_pkg::F_ALLOC: begin
            if (stat.too_big) begin
              cmd.res_we = 1'b1;
              cmd.res    = bba_pkg::R_TOO_LARGE;
              state_nxt  = bba_pkg::S_OUT;
            end else if (stat.no_space) begin
              cmd.res_we = 1'b1;
              cmd.res    = bba_pkg::R_NO_SPACE;
              state_nxt  = bba_pkg::S_OUT;
            end else begin
              cmd.op    = bba_pkg::OP_A_INIT;
              state_nxt = bba_pkg::S_A_RD;
            end
          end
          bba_pkg::F_FREE: begin
            if (stat.adr_null) begin
              state_nxt = bba_pkg::S_OUT;
            end else if (stat.adr_range) begin
              cmd.res_we = 1'b1;
              cmd.res    = bba_pkg::R_ILLEGAL;
              state_nxt  = bba_pkg::S_OUT;
            end else if (stat.adr_low) begin
              cmd.res_we = 1'b1;
              cmd.res    = bba_pkg::R_NOT_ALLOC;
              state_nxt  = bba_pkg::S_OUT;
            end else begin
              cmd.op    = bba_pkg::OP_F_INIT;
              state_nxt = bba_pkg::S_F_RD;
            end
          end
          bba_pkg::F_FREE_OWNER: state_nxt = bba_pkg::S_O_RD;
          bba_pkg::F_QUERY:      state_nxt = bba_pkg::S_OUT;
          default:               state_nxt = bba_pkg::S_OUT;
        endcase
      end
      // Leftmost-fit search: stackless depth-first walk over the heap.
      bba_pkg::S_A_RD: begin
        cmd.op    = bba_pkg::OP_RD_N;
        state_nxt = bba_pkg::S_A_VIS;
      end
      bba_pkg::S_A_VIS: begin
        if (stat.nst == bba_pkg::N_FREE) begin
          cmd.op    = bba_pkg::OP_A_FOUND;
          state_nxt = bba_pkg::S_A_SPL;
        end else if (stat.nst == bba_pkg::N_SPLIT && stat.lv_below_t) begin
          cmd.op    = bba_pkg::OP_A_DOWN;
          state_nxt = bba_pkg::S_A_RD;
        end else begin
          state_nxt = bba_pkg::S_A_UP;
        end
      end
      bba_pkg::S_A_UP: begin
        if (stat.n_root) begin
          cmd.res_we = 1'b1;
          cmd.res    = bba_pkg::R_NO_SPACE;
          state_nxt  = bba_pkg::S_OUT;
        end else if (stat.n_odd) begin
          cmd.op    = bba_pkg::OP_A_NEXT;
          state_nxt = bba_pkg::S_A_RD;
        end else begin
          cmd.op = bba_pkg::OP_A_UP;
        end
      end
      // Split the found block down to the target size.
      bba_pkg::S_A_SPL: begin
        if (stat.lv_at_t) begin
          cmd.op    = bba_pkg::OP_W_ALLOC;
          state_nxt = bba_pkg::S_OUT;
        end else begin
          cmd.op    = bba_pkg::OP_W_SPLIT;
          state_nxt = bba_pkg::S_A_SPR;
        end
      end
      bba_pkg::S_A_SPR: begin
        cmd.op    = bba_pkg::OP_W_RFREE;
        state_nxt = bba_pkg::S_A_SPL;
      end
      // Free by address: walk down by offset.
      bba_pkg::S_F_RD: begin
        cmd.op    = bba_pkg::OP_RD_N;
        state_nxt = bba_pkg::S_F_VIS;
      end
      bba_pkg::S_F_VIS: begin
        if (stat.nst == bba_pkg::N_ALLOC && stat.off_hit) begin
          cmd.op    = bba_pkg::OP_W_FREE;
          state_nxt = bba_pkg::S_M_RD;
        end else if (stat.nst == bba_pkg::N_SPLIT) begin
          cmd.op    = bba_pkg::OP_F_DOWN;
          state_nxt = bba_pkg::S_F_RD;
        end else begin
          cmd.res_we = 1'b1;
          cmd.res    = bba_pkg::R_NOT_ALLOC;
          state_nxt  = bba_pkg::S_OUT;
        end
      end
      // Merge walk from a freshly freed node toward the root.
      bba_pkg::S_M_RD: begin
        if (stat.n_root) begin
          state_nxt = merge_done;
        end else begin
          cmd.op    = bba_pkg::OP_RD_SIB;
          state_nxt = bba_pkg::S_M_CHK;
        end
      end
      bba_pkg::S_M_CHK: begin
        if (stat.nst == bba_pkg::N_FREE) begin
          cmd.op    = bba_pkg::OP_M_WN;
          state_nxt = bba_pkg::S_M_WS;
        end else begin
          state_nxt = merge_done;
        end
      end
      bba_pkg::S_M_WS: begin
        cmd.op    = bba_pkg::OP_M_WS;
        state_nxt = bba_pkg::S_M_WP;
      end
      bba_pkg::S_M_WP: begin
        cmd.op    = bba_pkg::OP_M_WP;
        state_nxt = bba_pkg::S_M_RD;
      end
      // Release-by-owner sweep over every node.
      bba_pkg::S_O_RD: begin
        cmd.op    = bba_pkg::OP_RD_SC;
        state_nxt = bba_pkg::S_O_CHK;
      end
      bba_pkg::S_O_CHK: begin
        if (stat.nst == bba_pkg::N_ALLOC && stat.own_hit) begin
          cmd.op    = bba_pkg::OP_O_FREE;
          state_nxt = bba_pkg::S_M_RD;
        end else begin
          state_nxt = bba_pkg::S_O_NEXT;
        end
      end
      bba_pkg::S_O_NEXT: begin
        if (stat.sc_last) begin
          state_nxt = bba_pkg::S_OUT;
        end else begin
          cmd.op    = bba_pkg::OP_SC_INC;
          state_nxt = bba_pkg::S_O_RD;
        end
      end
      bba_pkg::S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op    = bba_pkg::OP_LOAD_OUT;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/bba_dp.sv
`timescale 1ns / 1ps
module bba_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::stat_t               stat,
  input  logic [bba_pkg::FUNC_W-1:0]   in_func,
  input  logic [bba_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [bba_pkg::ADDR_W-1:0]   in_address,
  input  logic [bba_pkg::OWN_W-1:0]    in_owner,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bba_pkg::RES_W-1:0]    out_status,
  output logic [bba_pkg::ADDR_W-1:0]   out_result_address,
  output logic [bba_pkg::FB_W-1:0]     out_free_bytes
);

  localparam int unsigned IW = bba_pkg::IDX_W;
  localparam int unsigned LW = bba_pkg::LVL_W;
  localparam int unsigned FW = bba_pkg::FB_W;
  localparam int unsigned OW = bba_pkg::OFF_W;
  localparam int unsigned AW = bba_pkg::ADDR_W;
  localparam int unsigned NW = bba_pkg::NEED_W;
  localparam int unsigned CW = bba_pkg::CLOG_W;

  // Node tree memory: one write port, one registered read port.
  bba_pkg::node_t mem [0:bba_pkg::NODE_COUNT-1];
  bba_pkg::node_t rd_data_r, wd;
  logic           we, re;
  logic [IW-1:0]  wa, ra;

  logic [IW-1:0]  n_r, n_nxt, sc_r, sc_nxt;
  logic [LW-1:0]  lv_r, lv_nxt, tl_r, tl_nxt;
  logic [FW-1:0]  noff_r, noff_nxt, cnt_r, cnt_nxt;
  logic [OW-1:0]  off_r, off_nxt;
  bba_pkg::func_t func_r;
  logic [bba_pkg::SIZE_W-1:0] req_r;
  logic [AW-1:0]  adr_r, addr_r, addr_nxt;
  logic [bba_pkg::OWN_W-1:0]  who_r;
  bba_pkg::res_t  res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  bba_pkg::res_t  out_status_r;
  logic [AW-1:0]  out_addr_r;
  logic [FW-1:0]  out_fb_r;

  // Tree navigation.
  logic [IW-1:0]    left, right, parent, sib, rank;
  logic [FW-1:0]    half;
  logic [IW+OW-1:0] offw;
  logic [OW-1:0]    blk_off;
  logic [AW-1:0]    res_addr;
  logic [NW-1:0]    need;
  logic [CW-1:0]    clog;
  logic [LW-1:0]    t_calc;
  logic [AW+1:0]    adr_x;

  assign left     = {n_r[IW-2:0], 1'b1};
  assign right    = left + IW'(1);
  assign parent   = IW'((n_r - IW'(1)) >> 1);
  assign sib      = n_r[0] ? (n_r + IW'(1)) : (n_r - IW'(1));
  assign half     = FW'(bba_pkg::REGION_BYTES) >> (lv_r + LW'(1));
  assign rank     = IW'(n_r + IW'(1) - (IW'(1) << lv_r));
  assign offw     = {rank, OW'(0)} >> lv_r;
  assign blk_off  = offw[OW-1:0];
  assign res_addr = AW'(bba_pkg::BASE_ADDRESS + bba_pkg::HEADER_BYTES) + AW'(blk_off);

  // Rounded block size as a target level.
  assign need   = NW'(req_r[OW-1:0]) + NW'(bba_pkg::HEADER_BYTES);
  assign clog   = bba_pkg::bit_len(need - NW'(1));
  assign t_calc = (clog <= CW'(bba_pkg::LOG_MIN)) ? LW'(bba_pkg::LEAF_LVL)
                                                  : LW'(CW'(bba_pkg::LOG_REGION) - clog);
  assign adr_x  = (AW+2)'(adr_r);

  // Status toward the controller.
  always_comb begin
    stat.func       = func_r;
    stat.nst        = rd_data_r.st;
    stat.own_hit    = (rd_data_r.owner == who_r);
    stat.n_root     = (n_r == '0);
    stat.n_odd      = n_r[0];
    stat.lv_at_t    = (lv_r == tl_r);
    stat.lv_below_t = (lv_r < tl_r);
    stat.too_big    = (req_r >= bba_pkg::SIZE_W'(bba_pkg::REGION_BYTES));
    stat.no_space   = (clog > CW'(bba_pkg::LOG_REGION));
    stat.adr_null   = (adr_r == '0);
    stat.adr_range  = (adr_x < (AW+2)'(bba_pkg::BASE_ADDRESS)) ||
                      (adr_x > (AW+2)'(bba_pkg::BASE_ADDRESS + bba_pkg::REGION_BYTES));
    stat.adr_low    = (adr_x < (AW+2)'(bba_pkg::BASE_ADDRESS + bba_pkg::HEADER_BYTES));
    stat.off_hit    = (FW'(off_r) == noff_r);
    stat.sc_last    = (sc_r == IW'(bba_pkg::NODE_COUNT - 1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // Per-operation register updates and memory access.
  always_comb begin
    n_nxt    = n_r;
    lv_nxt   = lv_r;
    tl_nxt   = tl_r;
    sc_nxt   = sc_r;
    noff_nxt = noff_r;
    off_nxt  = off_r;
    cnt_nxt  = cnt_r;
    addr_nxt = addr_r;
    res_nxt  = cmd.res_we ? cmd.res : res_r;
    we       = 1'b0;
    wa       = n_r;
    wd.owner = '0;
    wd.st    = bba_pkg::N_UNUSED;
    re       = 1'b0;
    ra       = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      bba_pkg::OP_NONE: ;
      bba_pkg::OP_CLR: begin
        we     = 1'b1;
        wa     = sc_r;
        wd.st  = (sc_r == '0) ? bba_pkg::N_FREE : bba_pkg::N_UNUSED;
        sc_nxt = sc_r + IW'(1);
      end
      bba_pkg::OP_LATCH: begin
        sc_nxt   = '0;
        addr_nxt = '0;
        res_nxt  = bba_pkg::R_OK;
      end
      bba_pkg::OP_A_INIT: begin
        tl_nxt = t_calc;
        n_nxt  = '0;
        lv_nxt = '0;
      end
      bba_pkg::OP_RD_N: re = 1'b1;
      bba_pkg::OP_RD_SC: begin
        re = 1'b1;
        ra = sc_r;
      end
      bba_pkg::OP_RD_SIB: begin
        re = 1'b1;
        ra = sib;
      end
      bba_pkg::OP_A_DOWN: begin
        n_nxt  = left;
        lv_nxt = lv_r + LW'(1);
      end
      bba_pkg::OP_A_UP: begin
        n_nxt  = parent;
        lv_nxt = lv_r - LW'(1);
      end
      bba_pkg::OP_A_NEXT: n_nxt = n_r + IW'(1);
      bba_pkg::OP_A_FOUND: cnt_nxt = cnt_r - bba_pkg::net_bytes(lv_r);
      bba_pkg::OP_W_ALLOC: begin
        we       = 1'b1;
        wd.st    = bba_pkg::N_ALLOC;
        wd.owner = who_r;
        addr_nxt = res_addr;
      end
      bba_pkg::OP_W_SPLIT: begin
        we    = 1'b1;
        wd.st = bba_pkg::N_SPLIT;
      end
      bba_pkg::OP_W_RFREE: begin
        we      = 1'b1;
        wa      = right;
        wd.st   = bba_pkg::N_FREE;
        cnt_nxt = cnt_r + bba_pkg::net_bytes(lv_r + LW'(1));
        n_nxt   = left;
        lv_nxt  = lv_r + LW'(1);
      end
      bba_pkg::OP_F_INIT: begin
        off_nxt  = OW'(adr_r - AW'(bba_pkg::BASE_ADDRESS + bba_pkg::HEADER_BYTES));
        n_nxt    = '0;
        lv_nxt   = '0;
        noff_nxt = '0;
      end
      bba_pkg::OP_F_DOWN: begin
        if (FW'(off_r) >= noff_r + half) begin
          noff_nxt = noff_r + half;
          n_nxt    = right;
        end else begin
          n_nxt = left;
        end
        lv_nxt = lv_r + LW'(1);
      end
      bba_pkg::OP_W_FREE: begin
        we      = 1'b1;
        wd.st   = bba_pkg::N_FREE;
        cnt_nxt = cnt_r + bba_pkg::net_bytes(lv_r);
      end
      bba_pkg::OP_O_FREE: begin
        we      = 1'b1;
        wa      = sc_r;
        wd.st   = bba_pkg::N_FREE;
        n_nxt   = sc_r;
        lv_nxt  = bba_pkg::lvl_of(sc_r);
        cnt_nxt = cnt_r + bba_pkg::net_bytes(bba_pkg::lvl_of(sc_r));
      end
      bba_pkg::OP_M_WN: begin
        we      = 1'b1;
        cnt_nxt = cnt_r - bba_pkg::net_bytes(lv_r);
      end
      bba_pkg::OP_M_WS: begin
        we      = 1'b1;
        wa      = sib;
        cnt_nxt = cnt_r - bba_pkg::net_bytes(lv_r);
      end
      bba_pkg::OP_M_WP: begin
        we      = 1'b1;
        wa      = parent;
        wd.st   = bba_pkg::N_FREE;
        cnt_nxt = cnt_r + bba_pkg::net_bytes(lv_r - LW'(1));
        n_nxt   = parent;
        lv_nxt  = lv_r - LW'(1);
      end
      bba_pkg::OP_SC_INC: sc_nxt = sc_r + IW'(1);
      bba_pkg::OP_LOAD_OUT: out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  // Node memory.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r        <= '0;
      cnt_r       <= bba_pkg::net_bytes('0);
      out_valid_r <= 1'b0;
    end else begin
      sc_r        <= sc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    lv_r   <= lv_nxt;
    tl_r   <= tl_nxt;
    noff_r <= noff_nxt;
    off_r  <= off_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    if (cmd.op == bba_pkg::OP_LATCH) begin
      func_r <= bba_pkg::func_t'(in_func);
      req_r  <= in_request_size;
      adr_r  <= in_address;
      who_r  <= in_owner;
    end
    if (cmd.op == bba_pkg::OP_LOAD_OUT) begin
      out_status_r <= res_r;
      out_addr_r   <= addr_r;
      out_fb_r     <= cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_free_bytes     = out_fb_r;

  // The free-byte count never exceeds the whole region's net size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bba_pkg::net_bytes('0))
    else $error("free byte count out of range");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::OP_LOAD_OUT) |-> !(out_valid_r && !out_ready))
    else $error("result overwritten");

  // A successful allocation always yields a nonzero user address.
  a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bba_pkg::OP_W_ALLOC) |=> (addr_r != '0))
    else $error("allocation gave null address");

  // Memory writes stay inside the tree.
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (wa < IW'(bba_pkg::NODE_COUNT)))
    else $error("node write out of range");

endmodule

FILE: rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// Time to the result beat grows, for allocate, with the tree nodes visited and the split levels;
// for free by address, with the levels walked and the merges; for release by owner, with the
// nodes of the 2047-node tree and the merges.
// Throughput: one item at a time; the next beat is taken the cycle after a result is loaded.
// Reset (synchronous, active low) runs a clearing pass over all 2047 nodes of the node
// memory before the first beat is accepted.
module buddy_block_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bba_pkg::FUNC_W-1:0]   in_func,
  input  logic [bba_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [bba_pkg::ADDR_W-1:0]   in_address,
  input  logic [bba_pkg::OWN_W-1:0]    in_owner,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bba_pkg::RES_W-1:0]    out_status,
  output logic [bba_pkg::ADDR_W-1:0]   out_result_address,
  output logic [bba_pkg::FB_W-1:0]     out_free_bytes
);

  bba_pkg::cmd_t  cmd;
  bba_pkg::stat_t stat;

  // Sequencer.
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tree memory, walk registers and result register.
  bba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_request_size    (in_request_size),
    .in_address         (in_address),
    .in_owner           (in_owner),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_free_bytes     (out_free_bytes)
  );

endmodule
